>>> hdl/mrbt_pkg.sv
// Shared types, command codes and helpers of the message rate broadcast table.
// Used by the front queue, the table sequencer and the top level.
package mrbt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAX_RESULTS       = 16;
  localparam int MS_PER_SECOND     = 1000;
  localparam int VALUE_BYTES       = 4;
  localparam int PAYLOAD_BYTES     = 8;

  localparam logic [2:0] CMD_REGISTER   = 3'd0;
  localparam logic [2:0] CMD_UNREGISTER = 3'd1;
  localparam logic [2:0] CMD_ENABLE     = 3'd2;
  localparam logic [2:0] CMD_RATE       = 3'd3;
  localparam logic [2:0] CMD_MESSAGE    = 3'd4;
  localparam logic [2:0] CMD_TICK       = 3'd5;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  // One classified input item as it waits in the front queue.
  typedef struct packed {
    logic [2:0]  command;
    logic        bad_cmd;
    logic [31:0] msg_id;
    logic [15:0] rate_hz;
    logic        enable_bit;
    logic [31:0] value;
    logic [63:0] data;
    logic [3:0]  len;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [31:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic        last;
  } result_t;

  // Float equality: NaN never matches, the two zeros match each other.
  function automatic logic float_equal(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (a_nan || b_nan) begin
      return 1'b0;
    end
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      return 1'b1;
    end
    return a == b;
  endfunction

endpackage

>>> hdl/mrbt_front.sv
// Front part: accepts input beats, clamps and masks the message payload,
// and holds classified items in a two-entry queue. Depends on mrbt_pkg.
module mrbt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [2:0]            s_tuser,
  input  logic [151:0]          s_tdata,
  output logic                  q_valid,
  input  logic                  q_ready,
  output mrbt_pkg::item_t       q_item
);
  import mrbt_pkg::*;

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  item_t       cls;
  logic [63:0] payload;
  logic [3:0]  raw_len;
  logic        push;
  logic        pop;

  assign payload = s_tdata[112:49];
  assign raw_len = s_tdata[116:113];

  always_comb begin
    cls            = '0;
    cls.command    = s_tuser;
    cls.bad_cmd    = (s_tuser > CMD_TICK);
    cls.msg_id     = s_tdata[31:0];
    cls.rate_hz    = s_tdata[47:32];
    cls.enable_bit = s_tdata[48];
    cls.time_ms    = s_tdata[148:117];
    cls.len        = (raw_len > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES) : raw_len;
    cls.value      = (cls.len >= 4'(VALUE_BYTES)) ? payload[31:0] : 32'd0;
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      cls.data[8*b +: 8] = (4'(b) < cls.len) ? payload[8*b +: 8] : 8'd0;
    end
  end

  assign s_tready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hdl/mrbt_back.sv
// Back part: the entry table, the scan sequencer (one entry per cycle unless a tick
// frame waits on a stalled output) and the output register. Depends on mrbt_pkg.
module mrbt_back #(
  parameter int TABLE_ENTRIES = mrbt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              broadcast_on,
  input  logic              q_valid,
  output logic              q_ready,
  input  mrbt_pkg::item_t   q_item,
  output logic              m_valid,
  input  logic              m_ready,
  output mrbt_pkg::result_t m_res
);
  import mrbt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_ACT   = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [31:0] ident   [TABLE_ENTRIES];
  logic        enabled [TABLE_ENTRIES];
  logic [15:0] rate    [TABLE_ENTRIES];
  logic [31:0] sent    [TABLE_ENTRIES];
  logic [31:0] value   [TABLE_ENTRIES];
  logic        has     [TABLE_ENTRIES];

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [IW-1:0] hit;
  logic          found;
  logic          h_en;
  logic [15:0]   h_rate;
  logic [31:0]   h_val;
  logic          h_has;
  logic [4:0]    nres;
  item_t         cur;
  result_t       pend;
  logic          pend_valid;

  logic [IW-1:0] sel;
  logic [IW-1:0] last_slot;
  logic          at_end;
  logic          out_free;
  logic [31:0]   elapsed;
  logic [26:0]   span;
  logic          due;
  logic          reg_ok;
  logic          emit_msg;

  assign sel       = idx[IW-1:0];
  assign last_slot = IW'(count - CW'(1));
  assign at_end    = (idx >= count);
  assign out_free  = !m_valid || m_ready;
  assign q_ready   = (state == ST_IDLE);

  // Interval test without a divider: elapsed >= floor(1000/rate) holds exactly
  // when (elapsed + 1) * rate > 1000, and always once elapsed reaches 1000.
  assign elapsed = cur.time_ms - sent[sel];
  assign span    = 27'({1'b0, elapsed[9:0]} + 11'd1) * 27'(rate[sel]);
  assign due     = enabled[sel] && (rate[sel] != 16'd0) && has[sel] &&
                   ((elapsed >= 32'(MS_PER_SECOND)) || (span > 27'(MS_PER_SECOND)));

  assign reg_ok   = !found && (count < CW'(TABLE_ENTRIES));
  assign emit_msg = (h_rate == 16'd0) && !(h_has && float_equal(cur.value, h_val));

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_valid <= 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          cur   <= q_item;
          idx   <= '0;
          found <= 1'b0;
          nres  <= '0;
          if (q_item.bad_cmd) begin
            state <= ST_ACT;
          end else if (((q_item.command == CMD_MESSAGE) || (q_item.command == CMD_TICK))
                       && !broadcast_on) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cur.command == CMD_TICK) begin
          if (at_end || (nres == 5'(MAX_RESULTS))) begin
            state <= pend_valid ? ST_FLUSH : ST_IDLE;
          end else if (!due) begin
            idx <= idx + CW'(1);
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              m_valid <= 1'b1;
              m_res   <= pend;
            end
            pend            <= '0;
            pend.kind       <= KIND_FRAME;
            pend.ok         <= 1'b1;
            pend.frame_id   <= ident[sel];
            pend.frame_len  <= 4'(VALUE_BYTES);
            pend.frame_data <= {32'd0, value[sel]};
            pend_valid      <= 1'b1;
            sent[sel]       <= cur.time_ms;
            nres            <= nres + 5'd1;
            idx             <= idx + CW'(1);
          end
        end else if (at_end) begin
          state <= ST_ACT;
        end else if (ident[sel] == cur.msg_id) begin
          found  <= 1'b1;
          hit    <= sel;
          h_en   <= enabled[sel];
          h_rate <= rate[sel];
          h_val  <= value[sel];
          h_has  <= has[sel];
          state  <= ST_ACT;
        end else begin
          idx <= idx + CW'(1);
        end
      end
      ST_ACT: begin
        if (out_free) begin
          state   <= ST_IDLE;
          m_valid <= 1'b1;
          m_res   <= '0;
          m_res.kind <= KIND_STATUS;
          m_res.last <= 1'b1;
          if (cur.bad_cmd) begin
            m_res.ok <= 1'b0;
          end else begin
            case (cur.command)
              CMD_REGISTER: begin
                m_res.ok <= reg_ok;
                if (reg_ok) begin
                  ident[count[IW-1:0]]   <= cur.msg_id;
                  enabled[count[IW-1:0]] <= 1'b1;
                  rate[count[IW-1:0]]    <= cur.rate_hz;
                  sent[count[IW-1:0]]    <= 32'd0;
                  value[count[IW-1:0]]   <= 32'd0;
                  has[count[IW-1:0]]     <= 1'b0;
                  count                  <= count + CW'(1);
                end
              end
              CMD_UNREGISTER: begin
                m_res.ok <= found;
                if (found) begin
                  for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
                    if ((CW'(i) >= CW'(hit)) && (CW'(i + 1) < count)) begin
                      ident[i]   <= ident[i+1];
                      enabled[i] <= enabled[i+1];
                      rate[i]    <= rate[i+1];
                      sent[i]    <= sent[i+1];
                      value[i]   <= value[i+1];
                      has[i]     <= has[i+1];
                    end
                  end
                  ident[last_slot]   <= 32'd0;
                  enabled[last_slot] <= 1'b0;
                  count              <= count - CW'(1);
                end
              end
              CMD_ENABLE: begin
                m_res.ok <= found;
                if (found) begin
                  enabled[hit] <= cur.enable_bit;
                end
              end
              CMD_RATE: begin
                m_res.ok <= found;
                if (found) begin
                  rate[hit] <= cur.rate_hz;
                end
              end
              CMD_MESSAGE: begin
                m_valid <= 1'b0;
                if (found && h_en) begin
                  value[hit] <= cur.value;
                  has[hit]   <= 1'b1;
                  if (emit_msg) begin
                    m_valid          <= 1'b1;
                    m_res.kind       <= KIND_FRAME;
                    m_res.ok         <= 1'b1;
                    m_res.frame_id   <= cur.msg_id;
                    m_res.frame_len  <= cur.len;
                    m_res.frame_data <= cur.data;
                  end
                end
              end
              default: begin
                m_res.ok <= 1'b0;
              end
            endcase
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          m_valid    <= 1'b1;
          m_res      <= pend;
          m_res.last <= 1'b1;
          pend_valid <= 1'b0;
          state      <= ST_IDLE;
        end
      end
      default: begin
        state <= ST_IDLE;
      end
    endcase
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      nres       <= '0;
      pend_valid <= 1'b0;
      m_valid    <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ident[i]   <= 32'd0;
        enabled[i] <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !pend_valid)
    else $error("held tick frame left behind");

  assert property (@(posedge clk) disable iff (rst)
      (count == $past(count)) || (count == $past(count) + CW'(1)) ||
      (count + CW'(1) == $past(count)))
    else $error("entry count moved by more than one");

  assert property (@(posedge clk) disable iff (rst) nres <= 5'(MAX_RESULTS))
    else $error("tick produced too many frames");

endmodule

>>> hdl/message_rate_broadcast_table_core.sv
// Top level of the message rate broadcast table: stream ports, the
// configuration register and the front and back parts. Depends on mrbt_pkg.
//
// Each item passes a two-beat input queue, then the back part scans the table
// one entry per clock, except where a tick holds while a frame waits on a
// stalled output. A table command or message scans up to its matching entry,
// a tick all count entries or until it has sent MAX_RESULTS frames; the back
// part takes no new item until it is idle again, so throughput is set by the
// table scan. Command status is one beat with kind 0; frames carry kind 1.
// The last beat caused by an item has tlast set; messages and ticks that send
// nothing produce no beat.
module message_rate_broadcast_table_core #(
  parameter int TABLE_ENTRIES = mrbt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_data,   // broadcast_on
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [2:0]   s_tuser,    // command
  input  logic [151:0] s_tdata,    // msg_id, rate_hz, enable_bit, payload, payload_len, time_ms
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [0:0]   m_tuser,    // kind
  output logic [103:0] m_tdata,    // ok, frame_id, frame_len, frame_data
  output logic         m_tlast
);
  import mrbt_pkg::*;

  logic    broadcast_on;
  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      broadcast_on <= 1'b1;
    end else if (cfg_valid) begin
      broadcast_on <= cfg_data[0];
    end
  end

  mrbt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  mrbt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .broadcast_on (broadcast_on),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .m_valid      (m_tvalid),
    .m_ready      (m_tready),
    .m_res        (res)
  );

  assign m_tuser = res.kind;
  assign m_tlast = res.last;
  assign m_tdata = {3'd0, res.frame_data, res.frame_len, res.frame_id, res.ok};

endmodule
